// File: rtl/dlc_pkg.sv
// Package for the debounced LED chaser: ring size, field widths, register
// indexes, debounce phase codes and the step control struct.
// No dependencies.
`default_nettype none

package dlc_pkg;

    localparam int LED_COUNT = 5;

    localparam int PAT_W    = 5;
    localparam int PERIOD_W = 10;
    localparam int BOUNCE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_DELAY = 2'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;
    localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 8'd3;

    localparam logic [1:0] PHASE_OPEN   = 2'd0;
    localparam logic [1:0] PHASE_CLOSED = 2'd1;
    localparam logic [1:0] PHASE_BOUNCE = 2'd2;

    typedef struct packed {
        logic step;
        logic backward;
    } t_step_ctrl;

endpackage

`default_nettype wire

// File: rtl/dlc_debounce.sv
// Button debounce machine: open, closed and bounce phases with a hold-off
// counter; flags a new press. Depends on dlc_pkg.
`default_nettype none

module dlc_debounce
    import dlc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_pressed,
    input  wire logic [BOUNCE_W-1:0] i_bounce_delay,
    output logic                     o_new_press
);

    logic [1:0]          r_phase, n_phase;
    logic [BOUNCE_W-1:0] r_count, n_count;
    logic [BOUNCE_W-1:0] count_dec;

    always_comb begin
        count_dec   = (r_count != '0) ? r_count - 1'b1 : r_count;
        n_phase     = r_phase;
        n_count     = count_dec;
        o_new_press = 1'b0;
        case (r_phase)
            PHASE_CLOSED: begin
                if (!i_pressed) begin
                    n_phase = PHASE_BOUNCE;
                    n_count = i_bounce_delay;
                end
            end
            PHASE_BOUNCE: begin
                if (i_pressed) begin
                    n_phase = PHASE_CLOSED;
                end else if (count_dec == '0) begin
                    n_phase = PHASE_OPEN;
                end
            end
            default: begin
                if (i_pressed) begin
                    n_phase     = PHASE_CLOSED;
                    o_new_press = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_OPEN;
            r_count <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dlc_led_cell.sv
// One position of the LED ring; takes the bit of a neighbor on a step.
// Depends on dlc_pkg.
`default_nettype none

module dlc_led_cell
    import dlc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_step_ctrl i_ctrl,
    input  wire logic       i_from_lower,
    input  wire logic       i_from_upper,
    output logic            o_bit,
    output logic            o_next
);

    logic r_bit;

    assign o_next = !i_ctrl.step ? r_bit : (i_ctrl.backward ? i_from_upper : i_from_lower);
    assign o_bit  = r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= o_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/debounced_led_chaser_unit.sv
// Top level of the debounced LED chaser: config registers, tick counter,
// event latches, ring of dlc_led_cell and a two-entry output buffer.
// Depends on dlc_pkg, dlc_debounce, dlc_led_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one 10 ms tick: the raw
//   B1 level and a B5 press flag. Output channel (o_out_valid / i_out_ready)
//   returns one result per tick: LED pattern, direction and inversion.
//   A tick's result is registered into the output buffer when the tick
//   is transferred. Throughput: one tick per cycle while o_in_ready is high;
//   the state update (counter and mux logic) and the ring shift coincide.
//   The output side holds two results, so a tick is still taken while one
//   result waits; o_in_ready drops only when both entries are full, and
//   nothing is lost while the receiver stalls.
//   Config: i_cfg_we writes register i_cfg_idx (0 step_period,
//   1 bounce_delay) with i_cfg_data; other indexes are ignored. Write only
//   while idle.
//   Reset (i_rst_n low, synchronous): step_period 100, bounce_delay 3,
//   button open, no pending events, forward, not inverted, no LED lit,
//   tick count 100, output buffer empty.
`default_nettype none

module debounced_led_chaser_unit
    import dlc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_b1_level,
    input  wire logic                  i_b5_press,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [PAT_W-1:0]           o_led_pattern,
    output logic                       o_reversed,
    output logic                       o_inverted
);

    localparam int RES_W = PAT_W + 2;

    logic [PERIOD_W-1:0] r_step_period;
    logic [BOUNCE_W-1:0] r_bounce_delay;
    logic [PERIOD_W-1:0] r_tick, n_tick, tick_dec;
    logic                r_b1_pend, n_b1_pend, b1_pend_in;
    logic                r_b5_pend, n_b5_pend, b5_pend_in;
    logic                r_backward, n_backward;
    logic                r_invert, n_invert;
    logic                accept, step_due, new_press;
    t_step_ctrl          ctrl;

    logic [LED_COUNT-1:0] cell_bit, cell_next, from_lower, from_upper;
    logic                 no_pos;
    logic [PAT_W-1:0]     pattern;

    logic [RES_W-1:0] r_out, r_skid, result;
    logic             r_out_v, r_skid_v, pop;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period  <= PERIOD_RESET;
            r_bounce_delay <= BOUNCE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_PERIOD:  r_step_period  <= i_cfg_data[PERIOD_W-1:0];
                CFG_BOUNCE_DELAY: r_bounce_delay <= i_cfg_data[BOUNCE_W-1:0];
                default: ;
            endcase
        end
    end

    dlc_debounce u_debounce (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_pressed      (i_b1_level),
        .i_bounce_delay (r_bounce_delay),
        .o_new_press    (new_press)
    );

    always_comb begin
        b1_pend_in = r_b1_pend || new_press;
        b5_pend_in = r_b5_pend || i_b5_press;
        tick_dec   = (r_tick != '0) ? r_tick - 1'b1 : r_tick;
        step_due   = (tick_dec == '0);
        n_tick     = tick_dec;
        n_b1_pend  = b1_pend_in;
        n_b5_pend  = b5_pend_in;
        n_backward = r_backward;
        n_invert   = r_invert;
        if (step_due) begin
            n_tick = r_step_period;
        end else if (b1_pend_in) begin
            n_b1_pend  = 1'b0;
            n_backward = !r_backward;
        end else if (b5_pend_in) begin
            n_b5_pend = 1'b0;
            n_invert  = !r_invert;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= PERIOD_RESET;
            r_b1_pend  <= 1'b0;
            r_b5_pend  <= 1'b0;
            r_backward <= 1'b0;
            r_invert   <= 1'b0;
        end else if (accept) begin
            r_tick     <= n_tick;
            r_b1_pend  <= n_b1_pend;
            r_b5_pend  <= n_b5_pend;
            r_backward <= n_backward;
            r_invert   <= n_invert;
        end
    end

    // ring of cells; an empty ring seeds the first cell in the step direction
    assign ctrl.step     = accept && step_due;
    assign ctrl.backward = r_backward;
    assign no_pos        = (cell_bit == '0);

    genvar gi;
    generate
        for (gi = 0; gi < LED_COUNT; gi++) begin : g_cell
            if (gi == 0) begin : g_lo
                assign from_lower[gi] = cell_bit[LED_COUNT-1] || no_pos;
            end else begin : g_lo
                assign from_lower[gi] = cell_bit[gi-1];
            end
            if (gi == LED_COUNT - 1) begin : g_hi
                assign from_upper[gi] = cell_bit[0] || no_pos;
            end else begin : g_hi
                assign from_upper[gi] = cell_bit[gi+1];
            end
            dlc_led_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_from_lower (from_lower[gi]),
                .i_from_upper (from_upper[gi]),
                .o_bit        (cell_bit[gi]),
                .o_next       (cell_next[gi])
            );
        end
        for (gi = 0; gi < PAT_W; gi++) begin : g_pat
            if (gi < LED_COUNT) begin : g_on
                assign pattern[gi] = n_invert ? !cell_next[gi] : cell_next[gi];
            end else begin : g_off
                assign pattern[gi] = 1'b0;
            end
        end
    endgenerate

    assign result = {pattern, n_backward, n_invert};
    assign pop    = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || pop) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= accept;
                end else begin
                    r_out_v <= accept;
                end
            end else if (accept) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out <= r_skid;
                if (accept) begin
                    r_skid <= result;
                end
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_led_pattern = r_out[RES_W-1:2];
    assign o_reversed    = r_out[1];
    assign o_inverted    = r_out[0];

endmodule

`default_nettype wire

// File: rtl/dlc_checker.sv
// Port-level checks for debounced_led_chaser_unit, attached by bind.
// Depends on dlc_pkg.
`default_nettype none

module dlc_checker
    import dlc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_in_ready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [PAT_W-1:0]      o_led_pattern,
    input wire logic                  o_reversed,
    input wire logic                  o_inverted
);

    localparam int VIS_COUNT = (LED_COUNT < PAT_W) ? LED_COUNT : PAT_W;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_full_means_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_led_pattern)
            && $stable(o_reversed) && $stable(o_inverted))
        else $error("stalled result changed");

    a_one_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inverted |-> $countones(o_led_pattern) <= 1)
        else $error("more than one LED lit");

    a_one_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inverted |-> $countones(o_led_pattern) >= VIS_COUNT - 1)
        else $error("more than one LED dark");

endmodule

bind debounced_led_chaser_unit dlc_checker u_dlc_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for debounced_led_chaser_unit: a tick-by-tick model of the
// debounce, event latches and LED ring predicts every result transfer.
// Depends on dlc_pkg and the RTL of debounced_led_chaser_unit.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dlc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
    localparam logic [3:0] POS_NONE = 4'd15;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic             reversed;
        logic             inverted;
    } t_chase_view;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  b1_level  = 1'b0;
    logic                  b5_press  = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [PAT_W-1:0]      led_pattern;
    logic                  reversed;
    logic                  inverted;

    // model state
    logic [PERIOD_W-1:0] period_cfg   = PERIOD_RESET;
    logic [BOUNCE_W-1:0] bounce_cfg   = BOUNCE_RESET;
    logic [1:0]          btn_phase    = PHASE_OPEN;
    logic [BOUNCE_W-1:0] bounce_left  = '0;
    logic                b1_event     = 1'b0;
    logic                b5_event     = 1'b0;
    logic                backward_dir = 1'b0;
    logic                invert_on    = 1'b0;
    logic [3:0]          chase_pos    = POS_NONE;
    logic [PERIOD_W-1:0] tick_left    = PERIOD_RESET;

    t_chase_view expected_views[$];
    int          err_count   = 0;
    int          idle_cycles = 0;
    logic        tx_idle_en  = 1'b1;
    logic        rx_idle_en  = 1'b1;
    logic        rx_hold_req = 1'b0;
    logic        btn_drive   = 1'b0;
    int          btn_run     = 0;

    debounced_led_chaser_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_b1_level    (b1_level),
        .i_b5_press    (b5_press),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_led_pattern (led_pattern),
        .o_reversed    (reversed),
        .o_inverted    (inverted)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic t_chase_view chase_tick(input logic b1, input logic b5);
        t_chase_view v;
        int          all_on;
        int          one_hot;
        if (bounce_left != 0) bounce_left = bounce_left - 1'b1;
        case (btn_phase)
            PHASE_CLOSED: begin
                if (!b1) begin
                    btn_phase   = PHASE_BOUNCE;
                    bounce_left = bounce_cfg;
                end
            end
            PHASE_BOUNCE: begin
                if (b1) btn_phase = PHASE_CLOSED;
                else if (bounce_left == 0) btn_phase = PHASE_OPEN;
            end
            default: begin
                if (b1) begin
                    btn_phase = PHASE_CLOSED;
                    b1_event  = 1'b1;
                end
            end
        endcase
        if (b5) b5_event = 1'b1;

        if (tick_left != 0) tick_left = tick_left - 1'b1;
        if (tick_left == 0) begin
            if (!backward_dir)
                chase_pos = (chase_pos >= LED_COUNT - 1) ? 4'd0 : chase_pos + 4'd1;
            else if (chase_pos == 0 || chase_pos >= LED_COUNT)
                chase_pos = 4'(LED_COUNT - 1);
            else
                chase_pos = chase_pos - 4'd1;
            tick_left = period_cfg;
        end else if (b1_event) begin
            b1_event     = 1'b0;
            backward_dir = ~backward_dir;
        end else if (b5_event) begin
            b5_event  = 1'b0;
            invert_on = ~invert_on;
        end

        all_on    = (1 << LED_COUNT) - 1;
        one_hot   = (chase_pos < LED_COUNT) ? (1 << chase_pos) : 0;
        v.pattern  = PAT_W'((invert_on ? (all_on & ~one_hot) : one_hot) & 'h1F);
        v.reversed = backward_dir;
        v.inverted = invert_on;
        return v;
    endfunction

    task automatic send_tick(input logic b1, input logic b5);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        b1_level <= b1;
        b5_press <= b5;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_views.push_back(chase_tick(b1, b5));
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STEP_PERIOD:  period_cfg = data[PERIOD_W-1:0];
            CFG_BOUNCE_DELAY: bounce_cfg = data[BOUNCE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] period,
                              input logic [CFG_DATA_W-1:0] bounce);
        wait_results_done();
        write_reg(CFG_STEP_PERIOD, period);
        write_reg(CFG_BOUNCE_DELAY, bounce);
    endtask

    // press/release runs with chatter, rare long runs, one-tick glitches
    task automatic send_button_ticks(input int n);
        logic b1;
        for (int k = 0; k < n; k++) begin
            if (btn_run == 0) begin
                btn_drive = ~btn_drive;
                btn_run = ($urandom_range(0, 7) == 0) ?
                          $urandom_range(1, int'(bounce_cfg) + 20) : $urandom_range(1, 12);
            end
            btn_run--;
            b1 = btn_drive;
            if ($urandom_range(0, 15) == 0) b1 = ~b1;
            send_tick(b1, $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic test_reset_no_position();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);  // invert with no LED: all on
        send_tick(1'b1, 1'b0);  // press: reverse
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);  // release into bounce
        send_tick(1'b1, 1'b0);  // chatter back to closed, no event
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);  // new press after settle
        wait_results_done();
        write_reg(CFG_IDX_SPARE_A, '1);
        write_reg(CFG_IDX_SPARE_B, '0);
        write_reg(CFG_STEP_PERIOD, '0);
        write_reg(CFG_BOUNCE_DELAY, '0);
        // reach the first step backward and inverted, from no position
        while (chase_pos == POS_NONE)
            send_tick(!backward_dir && btn_phase == PHASE_OPEN, !invert_on);
    endtask

    task automatic test_zero_period();
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        set_config(10'd2, 10'h3FF);  // upper data bits dropped: 255
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    task automatic test_random_phases();
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: set_config(10'd1, 10'd0);
                1: set_config(10'd2, 10'h3FF);
                2: set_config(10'd5, 10'd2);
                3: set_config(CFG_DATA_W'($urandom_range(3, 15)),
                              CFG_DATA_W'($urandom_range(0, 8)));
                default: set_config(CFG_DATA_W'($urandom_range(1, 40)),
                                    CFG_DATA_W'($urandom));
            endcase
            send_button_ticks(80);
        end
    endtask

    task automatic test_long_period();
        set_config(10'h3FF, 10'h0FF);
        send_button_ticks(500);
        set_config(10'd4, 10'd1);   // applies after the long countdown
        send_button_ticks(600);
    endtask

    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        send_button_ticks(40);
        wait_results_done();
        tx_idle_en = 1'b1;
        send_button_ticks(20);
    endtask

    task automatic test_no_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_button_ticks(150);
    endtask

    initial begin : rx_proc
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                stall_left  = LONG_HOLD;
                rx_hold_req = 1'b0;
            end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_chase_view want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_views.size() == 0) begin
                $display("%0t: unexpected result transfer: pattern %b rev %b inv %b",
                         $time, led_pattern, reversed, inverted);
                err_count++;
            end else begin
                want = expected_views.pop_front();
                if (led_pattern !== want.pattern) begin
                    $display("%0t: led_pattern expected %b got %b",
                             $time, want.pattern, led_pattern);
                    err_count++;
                end
                if (reversed !== want.reversed) begin
                    $display("%0t: reversed expected %b got %b",
                             $time, want.reversed, reversed);
                    err_count++;
                end
                if (inverted !== want.inverted) begin
                    $display("%0t: inverted expected %b got %b",
                             $time, want.inverted, inverted);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_no_position();
        test_zero_period();
        test_random_phases();
        test_long_period();
        test_backpressure();
        test_no_idle();
        wait_results_done();
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/dlc_pkg.sv
rtl/dlc_debounce.sv
rtl/dlc_led_cell.sv
rtl/debounced_led_chaser_unit.sv
rtl/dlc_checker.sv
test/tb_top.sv
